FILE: design/smd_pkg.sv
// ----------------------------------------------------------------------------
// smd_pkg
// Widths, register indexes and reset values of the sliding-mode
// differentiator.
// ----------------------------------------------------------------------------
`default_nettype none
package smd_pkg;

  localparam int SAMPLE_W        = 32;
  localparam int SAMPLE_FRAC     = 24;
  localparam int STATE_W         = 48;
  localparam int STATE_FRAC_BITS = 24;
  localparam int STEP_W          = 25;
  localparam int STEP_FRAC       = 24;
  localparam int GAIN_W          = 32;
  localparam int GAIN_FRAC       = 16;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_INDEX_W     = 3;
  localparam int NUM_STATES      = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_STEP       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_3Q    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_HALF  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_QUART = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_SIGN  = 3'd4;

  localparam logic [STEP_W-1:0] STEP_RESET       = 25'd16777216;
  localparam logic [GAIN_W-1:0] GAIN_3Q_RESET    = 32'd349624;
  localparam logic [GAIN_W-1:0] GAIN_HALF_RESET  = 32'd862138;
  localparam logic [GAIN_W-1:0] GAIN_QUART_RESET = 32'd1127719;
  localparam logic [GAIN_W-1:0] GAIN_SIGN_RESET  = 32'd720896;

  typedef logic signed [STATE_W-1:0] state_t;

endpackage
`default_nettype wire

FILE: design/smd_if.sv
// ----------------------------------------------------------------------------
// smd_if
// Valid/ready channels for samples in and estimates out.
// ----------------------------------------------------------------------------
`default_nettype none
interface smd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [smd_pkg::SAMPLE_W-1:0]   sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface smd_out_if;
  logic             valid;
  logic             ready;
  smd_pkg::state_t  est_value;
  smd_pkg::state_t  est_first_deriv;
  smd_pkg::state_t  est_second_deriv;
  smd_pkg::state_t  est_third_deriv;
  modport source (output valid, output est_value, output est_first_deriv,
                  output est_second_deriv, output est_third_deriv, input ready);
  modport sink   (input valid, input est_value, input est_first_deriv,
                  input est_second_deriv, input est_third_deriv, output ready);
endinterface
`default_nettype wire

FILE: design/sliding_mode_differentiator_core.sv
// ----------------------------------------------------------------------------
// sliding_mode_differentiator_core
// Third-order robust exact differentiator on one shared sqrt step unit and
// one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Each sample beat passes through these steps from acceptance to the result
// beat: latch the sample, form the error, run the two bit-serial square roots
// with 64-bit results, compute eight products on the shared 32x32 multiplier
// (four partial products and a post-scale step each), and commit the
// estimates. The next sample is taken in the cycle after commit. A result beat
// waiting at the output does not stop that next sample, but holds its commit,
// and so the input after it, until accepted.
// ----------------------------------------------------------------------------
`default_nettype none
module sliding_mode_differentiator_core #(
  parameter int STATE_FRAC_BITS = smd_pkg::STATE_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  smd_in_if.sink                                in_chan,
  smd_out_if.source                             out_chan,
  input  wire logic                             cfg_we,
  input  wire logic [smd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [smd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SW  = smd_pkg::STATE_W;
  localparam int XUP = (STATE_FRAC_BITS >= smd_pkg::SAMPLE_FRAC) ?
                       STATE_FRAC_BITS - smd_pkg::SAMPLE_FRAC : 0;
  localparam int XDN = (STATE_FRAC_BITS < smd_pkg::SAMPLE_FRAC) ?
                       smd_pkg::SAMPLE_FRAC - STATE_FRAC_BITS : 0;
  localparam int GUP = (STATE_FRAC_BITS >= smd_pkg::GAIN_FRAC) ?
                       STATE_FRAC_BITS - smd_pkg::GAIN_FRAC : 0;
  localparam int GDN = (STATE_FRAC_BITS < smd_pkg::GAIN_FRAC) ?
                       smd_pkg::GAIN_FRAC - STATE_FRAC_BITS : 0;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ERR   = 3'd1;
  localparam logic [2:0] ST_ROOT1 = 3'd2;
  localparam logic [2:0] ST_ROOT2 = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_POST  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam logic [2:0] OP_T    = 3'd0;
  localparam logic [2:0] OP_G0   = 3'd1;
  localparam logic [2:0] OP_G1   = 3'd2;
  localparam logic [2:0] OP_G2   = 3'd3;
  localparam logic [2:0] OP_LAST = 3'd7;

  localparam logic signed [63:0] SAT_MAX = 64'sd140737488355327;
  localparam logic signed [63:0] SAT_MIN = -64'sd140737488355328;
  localparam logic [63:0]        INC_CAP = 64'd1 << 62;
  localparam logic [127:0]       HALF_LSB =
    128'd1 << (smd_pkg::STEP_FRAC - 1);

  // configuration
  logic [smd_pkg::STEP_W-1:0] step_r;
  logic [smd_pkg::GAIN_W-1:0] g34_r, g12_r, g14_r, gs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= smd_pkg::STEP_RESET;
      g34_r  <= smd_pkg::GAIN_3Q_RESET;
      g12_r  <= smd_pkg::GAIN_HALF_RESET;
      g14_r  <= smd_pkg::GAIN_QUART_RESET;
      gs_r   <= smd_pkg::GAIN_SIGN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smd_pkg::REG_STEP:       step_r <= cfg_data[smd_pkg::STEP_W-1:0];
        smd_pkg::REG_GAIN_3Q:    g34_r  <= cfg_data;
        smd_pkg::REG_GAIN_HALF:  g12_r  <= cfg_data;
        smd_pkg::REG_GAIN_QUART: g14_r  <= cfg_data;
        smd_pkg::REG_GAIN_SIGN:  gs_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [63:0] shr_sat(input logic [127:0] v, input int n);
    logic [127:0] s;
    s = v >> n;
    return (|s[127:64]) ? {64{1'b1}} : s[63:0];
  endfunction

  logic [2:0]   state_r;
  logic         primed_r;
  smd_pkg::state_t est_r [smd_pkg::NUM_STATES];
  smd_pkg::state_t nz_r  [smd_pkg::NUM_STATES];
  smd_pkg::state_t x_r;
  logic         sg_pos_r, sg_neg_r;
  logic [127:0] rad_r;
  logic [65:0]  rem_r;
  logic [63:0]  root_r;
  logic [5:0]   iter_r;
  logic [63:0]  s_r, q_r, t_r, g0_r, g1_r, g2_r;
  logic [2:0]   op_r;
  logic [1:0]   k_r;
  logic [127:0] acc_r;
  logic         out_valid_r;

  // sample to state format
  smd_pkg::state_t x_in;
  assign x_in = (SW'(in_chan.sample) <<< XUP) >>> XDN;

  logic [63:0] g3;
  assign g3 = (64'(gs_r) << GUP) >> GDN;

  // error and magnitude
  logic signed [SW:0] e_full;
  logic [SW:0]        e_mag;
  assign e_full = {est_r[0][SW-1], est_r[0]} - {x_r[SW-1], x_r};
  assign e_mag  = e_full[SW] ? (SW+1)'(-e_full) : e_full;

  // one digit of the square root
  logic [65:0] rem_shift, trial, rem_nxt;
  logic [63:0] root_nxt;
  always_comb begin
    rem_shift = {rem_r[63:0], rad_r[127:126]};
    trial     = {root_r, 2'b01};
    if (rem_shift >= trial) begin
      rem_nxt  = rem_shift - trial;
      root_nxt = {root_r[62:0], 1'b1};
    end else begin
      rem_nxt  = rem_shift;
      root_nxt = {root_r[62:0], 1'b0};
    end
  end

  // state derivatives, 64-bit wrapping like the step equations
  logic signed [63:0] dx [smd_pkg::NUM_STATES];
  logic signed [63:0] gsel [smd_pkg::NUM_STATES];
  always_comb begin
    gsel[0] = g0_r;
    gsel[1] = g1_r;
    gsel[2] = g2_r;
    gsel[3] = g3;
    for (int i = 0; i < smd_pkg::NUM_STATES; i++) begin
      logic signed [63:0] up;
      up = (i < smd_pkg::NUM_STATES - 1) ?
           64'(est_r[(i + 1) % smd_pkg::NUM_STATES]) : 64'sd0;
      if (sg_pos_r)      dx[i] = up - gsel[i];
      else if (sg_neg_r) dx[i] = up + gsel[i];
      else               dx[i] = up;
    end
  end

  logic [1:0] lane;
  assign lane = op_r[1:0];

  logic signed [63:0] dx_sel;
  logic [63:0]        dx_mag;
  assign dx_sel = dx[lane];
  assign dx_mag = dx_sel[63] ? 64'(-dx_sel) : dx_sel;

  // shared multiplier, one 32x32 partial product a cycle
  logic [63:0] mul_a, mul_b;
  always_comb begin
    case (op_r)
      OP_T:    begin mul_a = s_r;         mul_b = q_r; end
      OP_G0:   begin mul_a = 64'(g34_r);  mul_b = t_r; end
      OP_G1:   begin mul_a = 64'(g12_r);  mul_b = s_r; end
      OP_G2:   begin mul_a = 64'(g14_r);  mul_b = q_r; end
      default: begin mul_a = dx_mag;      mul_b = 64'(step_r); end
    endcase
  end

  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  assign pa = k_r[0] ? mul_a[63:32] : mul_a[31:0];
  assign pb = k_r[1] ? mul_b[63:32] : mul_b[31:0];
  assign pp = 64'(pa) * 64'(pb);
  always_comb begin
    case (k_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // post-scale of a finished product into a state update
  logic [63:0]        inc_raw, inc;
  logic signed [63:0] z_sum;
  smd_pkg::state_t    z_new;
  always_comb begin
    inc_raw = shr_sat(acc_r + HALF_LSB, smd_pkg::STEP_FRAC);
    inc     = (inc_raw > INC_CAP) ? INC_CAP : inc_raw;
    z_sum   = dx_sel[63] ? 64'(est_r[lane]) - $signed(inc)
                         : 64'(est_r[lane]) + $signed(inc);
    if (z_sum > SAT_MAX)      z_new = SW'(SAT_MAX);
    else if (z_sum < SAT_MIN) z_new = SW'(SAT_MIN);
    else                      z_new = z_sum[SW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < smd_pkg::NUM_STATES; i++) est_r[i] <= '0;
    end else begin
      // drop the beat once taken; commit sets it again in its own state
      if (out_valid_r && out_chan.ready && state_r != ST_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_chan.valid) begin
            x_r <= x_in;
            if (!primed_r) begin
              est_r[0] <= x_in;
              est_r[1] <= '0;
              est_r[2] <= '0;
              est_r[3] <= '0;
              primed_r <= 1'b1;
            end
            state_r <= ST_ERR;
          end
        end
        ST_ERR: begin
          sg_pos_r <= !e_full[SW] && (e_full != '0);
          sg_neg_r <= e_full[SW];
          rad_r    <= 128'(e_mag) << STATE_FRAC_BITS;
          rem_r    <= '0;
          root_r   <= '0;
          iter_r   <= '0;
          state_r  <= ST_ROOT1;
        end
        ST_ROOT1, ST_ROOT2: begin
          iter_r <= iter_r + 6'd1;
          if (iter_r == '1) begin
            rem_r  <= '0;
            root_r <= '0;
            if (state_r == ST_ROOT1) begin
              s_r     <= root_nxt;
              rad_r   <= 128'(root_nxt) << STATE_FRAC_BITS;
              state_r <= ST_ROOT2;
            end else begin
              q_r     <= root_nxt;
              op_r    <= OP_T;
              k_r     <= '0;
              acc_r   <= '0;
              state_r <= ST_MUL;
            end
          end else begin
            rad_r  <= {rad_r[125:0], 2'b00};
            rem_r  <= rem_nxt;
            root_r <= root_nxt;
          end
        end
        ST_MUL: begin
          acc_r <= acc_r + pp_sh;
          k_r   <= k_r + 2'd1;
          if (k_r == 2'd3) state_r <= ST_POST;
        end
        ST_POST: begin
          case (op_r)
            OP_T:    t_r  <= shr_sat(acc_r, STATE_FRAC_BITS);
            OP_G0:   g0_r <= shr_sat(acc_r, smd_pkg::GAIN_FRAC);
            OP_G1:   g1_r <= shr_sat(acc_r, smd_pkg::GAIN_FRAC);
            OP_G2:   g2_r <= shr_sat(acc_r, smd_pkg::GAIN_FRAC);
            default: nz_r[lane] <= z_new;
          endcase
          acc_r <= '0;
          k_r   <= '0;
          op_r  <= op_r + 3'd1;
          state_r <= (op_r == OP_LAST) ? ST_DONE : ST_MUL;
        end
        ST_DONE: begin
          // commit only when the output slot is free
          if (!out_valid_r || out_chan.ready) begin
            for (int i = 0; i < smd_pkg::NUM_STATES; i++) est_r[i] <= nz_r[i];
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_chan.ready             = (state_r == ST_IDLE);
  assign out_chan.valid            = out_valid_r;
  assign out_chan.est_value        = est_r[0];
  assign out_chan.est_first_deriv  = est_r[1];
  assign out_chan.est_second_deriv = est_r[2];
  assign out_chan.est_third_deriv  = est_r[3];

endmodule
`default_nettype wire

FILE: design/smd_checker.sv
// ----------------------------------------------------------------------------
// smd_checker
// Port-level checks of the differentiator core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module smd_checker (
  input wire logic            clk,
  input wire logic            rst_n,
  input wire logic            in_valid,
  input wire logic            in_ready,
  input wire logic            out_valid,
  input wire logic            out_ready,
  input wire smd_pkg::state_t out_value,
  input wire smd_pkg::state_t out_deriv
);

  // busy right after a sample beat
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core ready right after accepting a sample");

  // a new result appears together with the return to ready
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while core still busy");

  // no result appears while the core forms the error or starts the first root
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result too soon after sample");

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_deriv))
    else $error("stalled result changed");

endmodule

bind sliding_mode_differentiator_core smd_checker u_smd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_value (out_chan.est_value),
  .out_deriv (out_chan.est_first_deriv)
);
`default_nettype wire

FILE: bench/smd_estimate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smd_estimate_checker
// Watches the sample and estimate channels and the register port, keeps its
// own copy of the differentiator states and compares every estimate beat
// with the oldest predicted one.
// ----------------------------------------------------------------------------
module smd_estimate_checker
  import smd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  smd_in_if                      in_chan,
  smd_out_if                     out_chan,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  typedef struct {
    state_t z0;
    state_t z1;
    state_t z2;
    state_t z3;
  } estimate_t;

  localparam longint ST_MAX = 64'sd140737488355327;
  localparam longint ST_MIN = -64'sd140737488355328;

  longint            est_z[4];
  bit                primed;
  logic [STEP_W-1:0] step_h;
  logic [GAIN_W-1:0] k34, k12, k14, ks;
  estimate_t         estimate_fifo[$];

  assign pending = estimate_fifo.size();

  // floor(sqrt(v)), digit by digit over 64 bit pairs
  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [63:0]  root;
    logic [129:0] rem;
    logic [129:0] trial;
    root = '0;
    rem  = '0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | v[2*i +: 2];
      trial = ({66'd0, root} << 2) | 130'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // shift right, saturate to 64 bits
  function automatic logic [63:0] shr_clip(logic [127:0] p, int n);
    logic [127:0] r;
    r = p >> n;
    return (r[127:64] != 0) ? '1 : r[63:0];
  endfunction

  function automatic longint clip48(longint v);
    if (v > ST_MAX) return ST_MAX;
    if (v < ST_MIN) return ST_MIN;
    return v;
  endfunction

  function automatic longint euler_move(longint z, longint dx);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [63:0]  inc;
    mag  = dx < 0 ? 64'd0 - 64'(dx) : 64'(dx);
    prod = {64'd0, mag} * {103'd0, step_h} + (128'd1 << 23);
    inc  = shr_clip(prod, 24);
    if (inc > (64'd1 << 62)) inc = 64'd1 << 62;
    return clip48(dx < 0 ? z - longint'(inc) : z + longint'(inc));
  endfunction

  function automatic estimate_t track_sample(logic signed [SAMPLE_W-1:0] smp);
    longint      x, e, g3;
    longint      dx[4];
    longint      nz[4];
    logic [63:0] mag, s, q, t, g0, g1, g2;
    int          sg;
    estimate_t   r;
    x = smp;
    if (!primed) begin
      est_z[0] = x;
      est_z[1] = 0;
      est_z[2] = 0;
      est_z[3] = 0;
      primed   = 1'b1;
    end
    e   = est_z[0] - x;
    sg  = e > 0 ? 1 : (e < 0 ? -1 : 0);
    mag = e < 0 ? 64'd0 - 64'(e) : 64'(e);
    s   = isqrt({64'd0, mag} << STATE_FRAC_BITS);
    q   = isqrt({64'd0, s} << STATE_FRAC_BITS);
    t   = shr_clip({64'd0, s} * {64'd0, q}, STATE_FRAC_BITS);
    g0  = shr_clip({96'd0, k34} * {64'd0, t}, GAIN_FRAC);
    g1  = shr_clip({96'd0, k12} * {64'd0, s}, GAIN_FRAC);
    g2  = shr_clip({96'd0, k14} * {64'd0, q}, GAIN_FRAC);
    g3  = longint'({32'd0, ks}) << (STATE_FRAC_BITS - GAIN_FRAC);
    dx[0] = est_z[1] - longint'(sg) * longint'(g0);
    dx[1] = est_z[2] - longint'(sg) * longint'(g1);
    dx[2] = est_z[3] - longint'(sg) * longint'(g2);
    dx[3] = -longint'(sg) * g3;
    for (int i = 0; i < 4; i++) nz[i] = euler_move(est_z[i], dx[i]);
    for (int i = 0; i < 4; i++) est_z[i] = nz[i];
    r.z0 = est_z[0][STATE_W-1:0];
    r.z1 = est_z[1][STATE_W-1:0];
    r.z2 = est_z[2][STATE_W-1:0];
    r.z3 = est_z[3][STATE_W-1:0];
    return r;
  endfunction

  task automatic check_field(string name, state_t want, state_t got);
    if (want !== got) begin
      $error("%s expected %0d got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    estimate_t want;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) est_z[i] = 0;
      primed     = 1'b0;
      step_h     = STEP_RESET;
      k34        = GAIN_3Q_RESET;
      k12        = GAIN_HALF_RESET;
      k14        = GAIN_QUART_RESET;
      ks         = GAIN_SIGN_RESET;
      fail_count = 0;
      estimate_fifo.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP:       step_h = cfg_data[STEP_W-1:0];
          REG_GAIN_3Q:    k34    = cfg_data;
          REG_GAIN_HALF:  k12    = cfg_data;
          REG_GAIN_QUART: k14    = cfg_data;
          REG_GAIN_SIGN:  ks     = cfg_data;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready)
        estimate_fifo.push_back(track_sample(in_chan.sample));
      if (out_chan.valid && out_chan.ready) begin
        if (estimate_fifo.size() == 0) begin
          $error("estimate beat with nothing expected");
          fail_count++;
        end else begin
          want = estimate_fifo.pop_front();
          check_field("est_value", want.z0, out_chan.est_value);
          check_field("est_first_deriv", want.z1, out_chan.est_first_deriv);
          check_field("est_second_deriv", want.z2, out_chan.est_second_deriv);
          check_field("est_third_deriv", want.z3, out_chan.est_third_deriv);
        end
      end
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives samples and register writes into the sliding-mode differentiator
// across several gain and step settings and idle patterns; a checker beside
// the block predicts and compares every estimate beat.
// ----------------------------------------------------------------------------
module tb;
  import smd_pkg::*;

  localparam int WATCH_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int PHASE_ITEMS = 240;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fail_count;
  int                     pending;
  int                     idle_pct = 0;
  int                     stall_pct = 0;
  bit                     hold_req = 1'b0;
  int                     hold_left = 0;
  int                     quiet_cycles = 0;

  smd_in_if  in_chan ();
  smd_out_if out_chan ();

  initial begin
    in_chan.valid  = 1'b0;
    in_chan.sample = '0;
    out_chan.ready = 1'b0;
  end

  always #1 clk = ~clk;

  sliding_mode_differentiator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  smd_estimate_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("[sliding_mode_differentiator_core] ERROR");
      $finish;
    end
  end

  task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
    bit got;
    if ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid  <= 1'b1;
    in_chan.sample <= x;
    do begin
      @(negedge clk);
      got = in_chan.ready;
      @(posedge clk);
    end while (!got);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic drain;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(int p);
    case (p)
      0: ;
      1: begin
        write_reg(REG_STEP, 32'd0);
        write_reg(REG_GAIN_SIGN, 32'hFFFF_FFFF);
      end
      2: begin
        write_reg(REG_STEP, 32'hFFFF_FFFF);
        write_reg(REG_GAIN_3Q, 32'hFFFF_FFFF);
        write_reg(REG_GAIN_HALF, 32'hFFFF_FFFF);
        write_reg(REG_GAIN_QUART, 32'hFFFF_FFFF);
      end
      3: begin
        write_reg(REG_STEP, 32'd1);
        write_reg(REG_GAIN_3Q, 32'd0);
        write_reg(REG_GAIN_HALF, 32'd0);
        write_reg(REG_GAIN_QUART, 32'd0);
        write_reg(REG_GAIN_SIGN, 32'd0);
      end
      4: begin
        write_reg(REG_STEP, 32'd167772);
        write_reg(REG_GAIN_3Q, GAIN_3Q_RESET);
        write_reg(REG_GAIN_HALF, GAIN_HALF_RESET);
        write_reg(REG_GAIN_QUART, GAIN_QUART_RESET);
        write_reg(REG_GAIN_SIGN, GAIN_SIGN_RESET);
      end
      default: begin
        write_reg(REG_STEP, $urandom);
        write_reg(REG_GAIN_3Q, $urandom_range(1 << 22));
        write_reg(REG_GAIN_HALF, $urandom_range(1 << 22));
        write_reg(REG_GAIN_QUART, $urandom_range(1 << 22));
        write_reg(REG_GAIN_SIGN, $urandom_range(1 << 22));
        // unused indexes must not disturb anything
        write_reg(3'd5, $urandom);
        write_reg(3'd7, $urandom);
      end
    endcase
  endtask

  initial begin
    logic signed [SAMPLE_W-1:0] walk;
    logic signed [SAMPLE_W-1:0] d;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: priming sample, repeats, extremes, small steps
    send_sample(32'sd16777216);
    send_sample(32'sd16777216);
    send_sample(32'sd16777216);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(-32'sd1);
    send_sample(32'sd0);
    send_sample(32'sd1);
    send_sample(32'sd0);
    send_sample(32'sh5555_5555);
    send_sample(32'shAAAA_AAAA);
    send_sample(32'sh8000_0000);
    send_sample(32'sh8000_0000);
    drain();

    walk = 32'sd0;
    for (int p = 0; p < 8; p++) begin
      load_setting(p);
      idle_pct  = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 7 : 45) : 0;
      stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 7 : 45) : 0;
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(9) < 8) begin
          // smooth signal with random slope changes
          d    = $signed($urandom_range(1 << 20)) - (1 << 19);
          walk = walk + d;
          send_sample(walk);
        end else begin
          send_sample($urandom);
        end
      end
      drain();
    end

    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[sliding_mode_differentiator_core] OK");
    else
      $display("[sliding_mode_differentiator_core] ERROR");
    $finish;
  end

endmodule
